[rtl/txcw_pkg.sv]
package txcw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;

	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int RW     = $clog2(ROWS);
	localparam int CW     = $clog2(COLUMNS);

	localparam int ROW_W   = 5;
	localparam int COL_W   = 7;
	localparam int LOC_W   = 11;
	localparam int INDEX_W = 11;
	localparam int WORD_W  = 16;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] SPACE_CODE   = 8'd32;
	localparam logic [7:0] RESET_COLOR  = 8'd9;

	typedef enum logic [1:0] {
		ACT_PUT     = 2'd0,
		ACT_ADVANCE = 2'd1,
		ACT_CLEAR   = 2'd2,
		ACT_READ    = 2'd3
	} action_t;

	typedef struct packed {
		logic       en;
		action_t    action;
		logic       newline;
	} cursor_cmd_t;

	typedef struct packed {
		logic [RW-1:0]     row;
		logic [CW-1:0]     col;
		logic [ADDR_W-1:0] loc;
	} cursor_t;

endpackage

[rtl/txcw_cell_ram.sv]
module txcw_cell_ram import txcw_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [CELL_COUNT];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// A read of the entry being written in the same cycle returns the new word.
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata <= wdata;
			end else begin
				rdata <= mem[raddr];
			end
		end
	end

endmodule

[rtl/txcw_cursor.sv]
module txcw_cursor import txcw_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cursor_cmd_t cmd,
	output cursor_t     cur,
	output cursor_t     nxt,
	output logic        scroll
);

	logic              at_eol;
	logic              at_bot;
	logic              step_nl;
	logic [ADDR_W-1:0] line_start;

	always_comb begin
		at_eol     = (cur.col == CW'(COLUMNS - 1));
		at_bot     = (cur.row == RW'(ROWS - 1));
		line_start = cur.loc - ADDR_W'(cur.col);
		nxt        = cur;
		scroll     = 1'b0;
		step_nl    = 1'b0;
		case (cmd.action)
			ACT_PUT: begin
				if (cmd.newline) begin
					step_nl = 1'b1;
				end else if (!at_eol) begin
					nxt.col = cur.col + CW'(1);
					nxt.loc = cur.loc + ADDR_W'(1);
				end else if (at_bot) begin
					nxt = '0;
				end else begin
					nxt.row = cur.row + RW'(1);
					nxt.col = '0;
					nxt.loc = cur.loc + ADDR_W'(1);
				end
			end
			ACT_ADVANCE: begin
				if (!at_eol) begin
					nxt.col = cur.col + CW'(1);
					nxt.loc = cur.loc + ADDR_W'(1);
				end else begin
					step_nl = 1'b1;
				end
			end
			ACT_CLEAR: begin
				nxt = '0;
			end
			default: begin
			end
		endcase
		if (step_nl) begin
			nxt.col = '0;
			if (at_bot) begin
				nxt.loc = line_start;
				scroll  = 1'b1;
			end else begin
				nxt.row = cur.row + RW'(1);
				nxt.loc = line_start + ADDR_W'(COLUMNS);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur <= '0;
		end else if (cmd.en) begin
			cur <= nxt;
		end
	end

endmodule

[rtl/text_console_writer_core.sv]
// Text console engine with a 25 x 80 cell store and a cursor.
// Input channel (in_valid/in_ready) carries action, char_code and cell_index;
// the output channel (out_valid/out_ready) returns one transaction per input
// with the cursor after the action, the cursor update and scroll flags, and
// the cell word for a read. The configuration channel (cfg_valid/cfg_ready)
// writes text_color and is always ready.
// A put character or an advance without scroll needs no further state, so
// such items can follow every cycle while the receiver takes each result.
// A read passes through S_READ, as the cell memory returns a registered word.
// A scroll or a clear walks the whole cell memory through its single write
// port, one cell per cycle. After reset the block runs the same walk to fill
// the store with blanks in the reset color, during which in_ready stays low.
// One item is in work at a time; a new item is taken only when the output
// register is empty or is being emptied, so a stalled receiver holds the
// block with its result kept stable.
module text_console_writer_core import txcw_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [7:0]         char_code,
	input  logic [INDEX_W-1:0] cell_index,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ROW_W-1:0]   cursor_row,
	output logic [COL_W-1:0]   cursor_column,
	output logic [LOC_W-1:0]   cursor_location,
	output logic               cursor_update,
	output logic               screen_scrolled,
	output logic [WORD_W-1:0]  cell_word,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         text_color
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_READ   = 4'b0010,
		S_SCROLL = 4'b0100,
		S_FILL   = 4'b1000
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] cnt_q;
	logic              report_q;
	logic [WORD_W-1:0] fill_word_q;
	logic [7:0]        text_color_q;
	logic              out_valid_q;
	logic              oob_q;

	logic              wv_s1;
	logic              wcopy_s1;
	logic [ADDR_W-1:0] wa_s1;
	logic [WORD_W-1:0] wd_s1;

	logic [ROW_W-1:0]  out_row_q;
	logic [COL_W-1:0]  out_col_q;
	logic [LOC_W-1:0]  out_loc_q;
	logic              out_update_q;
	logic              out_scrolled_q;
	logic [WORD_W-1:0] out_word_q;

	action_t           act;
	logic              accept;
	logic              newline;
	logic              cnt_last;
	logic              copy_phase;
	logic [WORD_W-1:0] blank_word;
	cursor_cmd_t       cmd;
	cursor_t           cur;
	cursor_t           nxt;
	logic              need_scroll;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	assign act        = action_t'(action);
	assign in_ready   = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept     = in_valid && in_ready;
	assign newline    = (char_code == NEWLINE_CODE);
	assign cnt_last   = (cnt_q == ADDR_W'(CELL_COUNT - 1));
	assign copy_phase = (cnt_q < ADDR_W'(CELL_COUNT - COLUMNS));
	assign blank_word = {text_color_q, SPACE_CODE};
	assign cfg_ready  = 1'b1;

	assign cmd.en      = accept;
	assign cmd.action  = act;
	assign cmd.newline = newline;

	txcw_cursor u_cursor (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.cur    (cur),
		.nxt    (nxt),
		.scroll (need_scroll)
	);

	assign ram_we    = wv_s1;
	assign ram_waddr = wa_s1;
	assign ram_wdata = wcopy_s1 ? ram_rdata : wd_s1;
	assign ram_re    = (accept && (act == ACT_READ)) || ((state_q == S_SCROLL) && copy_phase);
	assign ram_raddr = (state_q == S_SCROLL) ? (cnt_q + ADDR_W'(COLUMNS))
		: ADDR_W'(cell_index);

	txcw_cell_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= RESET_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			text_color_q <= text_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL;
			cnt_q       <= '0;
			report_q    <= 1'b0;
			fill_word_q <= {RESET_COLOR, SPACE_CODE};
			out_valid_q <= 1'b0;
			wv_s1       <= 1'b0;
		end else begin
			wv_s1 <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (act == ACT_READ) begin
							state_q <= S_READ;
						end else if (act == ACT_CLEAR) begin
							state_q     <= S_FILL;
							cnt_q       <= '0;
							report_q    <= 1'b1;
							fill_word_q <= blank_word;
						end else if (need_scroll) begin
							state_q <= S_SCROLL;
							cnt_q   <= '0;
						end else begin
							out_valid_q <= 1'b1;
							wv_s1       <= (act == ACT_PUT) && !newline;
						end
					end
				end
				S_READ: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_SCROLL: begin
					wv_s1 <= 1'b1;
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_last) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				S_FILL: begin
					wv_s1 <= 1'b1;
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_last) begin
						state_q <= S_IDLE;
						if (report_q) begin
							out_valid_q <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_SCROLL: begin
				wa_s1    <= cnt_q;
				wd_s1    <= blank_word;
				wcopy_s1 <= copy_phase;
			end
			S_FILL: begin
				wa_s1    <= cnt_q;
				wd_s1    <= fill_word_q;
				wcopy_s1 <= 1'b0;
			end
			default: begin
				wa_s1    <= cur.loc;
				wd_s1    <= {text_color_q, char_code};
				wcopy_s1 <= 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_row_q      <= ROW_W'(nxt.row);
			out_col_q      <= COL_W'(nxt.col);
			out_loc_q      <= LOC_W'(nxt.loc);
			out_update_q   <= ((act == ACT_PUT) && newline) || (act == ACT_ADVANCE);
			out_scrolled_q <= need_scroll;
			out_word_q     <= '0;
			oob_q          <= (int'(cell_index) >= CELL_COUNT);
		end else if (state_q == S_READ) begin
			out_word_q <= oob_q ? '0 : ram_rdata;
		end
	end

	assign out_valid       = out_valid_q;
	assign cursor_row      = out_row_q;
	assign cursor_column   = out_col_q;
	assign cursor_location = out_loc_q;
	assign cursor_update   = out_update_q;
	assign screen_scrolled = out_scrolled_q;
	assign cell_word       = out_word_q;

endmodule
